### hw/rtl/svm_pkg.sv
// Shared constants and stage payload types for the space vector modulator.
`timescale 1ns / 1ps

package svm_pkg;

   // Sixty degrees in angle units (full circle = 65536).
   localparam int unsigned A60 = 10923;
   // 2*pi in Q30.
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

   localparam int FRAC_BITS_DEF      = 15;
   localparam int SINE_ADDR_BITS_DEF = 10;

   localparam int ANGLE_BITS  = 16;
   localparam int AMP_BITS    = 15;
   localparam int TIME_BITS   = 16;
   localparam int SECTOR_BITS = 3;

   // Command fields carried along with the sine lookups.
   typedef struct packed {
      logic [SECTOR_BITS-1:0] sector;
      logic [AMP_BITS-1:0]    amp;
   } cmd_type;

   // Scaled active times.
   typedef struct packed {
      logic [SECTOR_BITS-1:0] sector;
      logic [TIME_BITS-1:0]   t1;
      logic [TIME_BITS-1:0]   t2;
   } times_type;

endpackage

### hw/rtl/svm_req_if.sv
// Request channel: one modulation command per beat.
`timescale 1ns / 1ps

interface svm_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [15:0] rotor_angle;
   logic [15:0] command_angle;
   logic signed [15:0] amplitude;

   modport source (output valid, mode, rotor_angle, command_angle, amplitude,
                   input ready);
   modport sink (input valid, mode, rotor_angle, command_angle, amplitude,
                 output ready);
endinterface

### hw/rtl/svm_rsp_if.sv
// Response channel: sector, vector times and phase compare values per beat.
`timescale 1ns / 1ps

interface svm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  sector;
   logic [15:0] zero_time;
   logic [15:0] active_time_one;
   logic [15:0] active_time_two;
   logic [15:0] compare_u;
   logic [15:0] compare_v;
   logic [15:0] compare_w;

   modport source (output valid, sector, zero_time, active_time_one, active_time_two,
                   compare_u, compare_v, compare_w, input ready);
   modport sink (input valid, sector, zero_time, active_time_one, active_time_two,
                 compare_u, compare_v, compare_w, output ready);
endinterface

### hw/rtl/svm_front.sv
// Angle select, amplitude clamp, sector split and sine ROM addressing (two stages).
`timescale 1ns / 1ps

module svm_front #(
   parameter int SINE_ADDR_BITS = svm_pkg::SINE_ADDR_BITS_DEF,
   parameter int ROM_ADDR_BITS  = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic                      mode,
   input  logic [15:0]               rotor_angle,
   input  logic [15:0]               command_angle,
   input  logic signed [15:0]        amplitude,
   input  logic [15:0]               amplitude_limit,
   output logic                      out_valid,
   input  logic                      out_ready,
   output svm_pkg::cmd_type          out_cmd,
   output logic [ROM_ADDR_BITS-1:0]  addr_a,
   output logic [ROM_ADDR_BITS-1:0]  addr_b
);

   localparam int SHIFT = 16 - SINE_ADDR_BITS;
   localparam logic [15:0] A60_W = 16'(svm_pkg::A60);
   localparam logic [15:0] TH1 = 16'(svm_pkg::A60 * 1);
   localparam logic [15:0] TH2 = 16'(svm_pkg::A60 * 2);
   localparam logic [15:0] TH3 = 16'(svm_pkg::A60 * 3);
   localparam logic [15:0] TH4 = 16'(svm_pkg::A60 * 4);
   localparam logic [15:0] TH5 = 16'(svm_pkg::A60 * 5);

   // stage 1
   logic                          v1_ff;
   logic [15:0]                   angle_ff, angle_in;
   logic [svm_pkg::AMP_BITS-1:0]  amp1_ff, amp1_in;
   logic                          en1;

   // stage 2
   logic                          v2_ff;
   svm_pkg::cmd_type              cmd_ff, cmd_in;
   logic [ROM_ADDR_BITS-1:0]      addr_a_ff, addr_a_in;
   logic [ROM_ADDR_BITS-1:0]      addr_b_ff, addr_b_in;
   logic                          en2;

   logic [2:0]                    sector;
   logic [15:0]                   base;
   logic [15:0]                   offset;
   logic [15:0]                   comp_off;
   logic [15:0]                   amp_sel;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_comb begin
      angle_in = mode ? (rotor_angle + command_angle) : command_angle;
      if (amplitude[15]) begin
         amp_sel = 16'd0;
      end else if (16'(amplitude) > amplitude_limit) begin
         amp_sel = amplitude_limit;
      end else begin
         amp_sel = 16'(amplitude);
      end
      // a positive amplitude never exceeds 15 bits, so neither does the clamp
      amp1_in = amp_sel[svm_pkg::AMP_BITS-1:0];
   end

   always_comb begin
      if (angle_ff >= TH5) begin
         sector = 3'd5;
         base   = TH5;
      end else if (angle_ff >= TH4) begin
         sector = 3'd4;
         base   = TH4;
      end else if (angle_ff >= TH3) begin
         sector = 3'd3;
         base   = TH3;
      end else if (angle_ff >= TH2) begin
         sector = 3'd2;
         base   = TH2;
      end else if (angle_ff >= TH1) begin
         sector = 3'd1;
         base   = TH1;
      end else begin
         sector = 3'd0;
         base   = 16'd0;
      end
      offset   = angle_ff - base;
      comp_off = A60_W - offset;
      cmd_in.sector = sector;
      cmd_in.amp    = amp1_ff;
      addr_a_in = ROM_ADDR_BITS'(comp_off >> SHIFT);
      addr_b_in = ROM_ADDR_BITS'(offset >> SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         angle_ff <= angle_in;
         amp1_ff  <= amp1_in;
      end
      if (en2) begin
         cmd_ff    <= cmd_in;
         addr_a_ff <= addr_a_in;
         addr_b_ff <= addr_b_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_cmd   = cmd_ff;
   assign addr_a    = addr_a_ff;
   assign addr_b    = addr_b_ff;

endmodule

### hw/rtl/svm_sine_rom.sv
// Two-port sine ROM over the first sextant, registered read (one stage).
`timescale 1ns / 1ps

module svm_sine_rom #(
   parameter int FRAC_BITS      = svm_pkg::FRAC_BITS_DEF,
   parameter int SINE_ADDR_BITS = svm_pkg::SINE_ADDR_BITS_DEF,
   parameter int ROM_ADDR_BITS  = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  svm_pkg::cmd_type          in_cmd,
   input  logic [ROM_ADDR_BITS-1:0]  addr_a,
   input  logic [ROM_ADDR_BITS-1:0]  addr_b,
   output logic                      out_valid,
   input  logic                      out_ready,
   output svm_pkg::cmd_type          out_cmd,
   output logic [FRAC_BITS-1:0]      sin_a,
   output logic [FRAC_BITS-1:0]      sin_b
);

   localparam int DEPTH = int'(svm_pkg::A60 >> (16 - SINE_ADDR_BITS)) + 1;

   typedef logic [FRAC_BITS-1:0] rom_type [DEPTH];

   function automatic logic [63:0] series_div(input logic [63:0] val, input int n);
      logic [63:0] q;
      case (n)
         1:       q = val / 64'd6;
         2:       q = val / 64'd20;
         3:       q = val / 64'd42;
         4:       q = val / 64'd72;
         5:       q = val / 64'd110;
         6:       q = val / 64'd156;
         default: q = val / 64'd210;
      endcase
      return q;
   endfunction

   // sin by odd Taylor terms in Q30, rounded to FRAC_BITS
   function automatic logic [FRAC_BITS-1:0] rom_entry(input int k);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        rounded;
      x    = (svm_pkg::TWO_PI_Q30 * 64'(k)) >> SINE_ADDR_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int n = 1; n <= 7; n++) begin
         term = series_div((term * x2) >> 30, n);
         if (n[0]) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      rounded = (64'(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      return rounded[FRAC_BITS-1:0];
   endfunction

   function automatic rom_type build_rom();
      rom_type r;
      for (int k = 0; k < DEPTH; k++) begin
         r[k] = rom_entry(k);
      end
      return r;
   endfunction

   localparam rom_type SINE_TABLE = build_rom();

   logic                  v_ff;
   svm_pkg::cmd_type      cmd_ff;
   logic [FRAC_BITS-1:0]  sin_a_ff;
   logic [FRAC_BITS-1:0]  sin_b_ff;
   logic                  en;

   assign en       = !v_ff || out_ready;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmd_ff   <= in_cmd;
         sin_a_ff <= SINE_TABLE[addr_a];
         sin_b_ff <= SINE_TABLE[addr_b];
      end
   end

   assign out_valid = v_ff;
   assign out_cmd   = cmd_ff;
   assign sin_a     = sin_a_ff;
   assign sin_b     = sin_b_ff;

endmodule

### hw/rtl/svm_scale.sv
// Amplitude and period scaling of both sine values (two multiplier stages).
`timescale 1ns / 1ps

module svm_scale #(
   parameter int FRAC_BITS = svm_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  svm_pkg::cmd_type      in_cmd,
   input  logic [FRAC_BITS-1:0]  sin_a,
   input  logic [FRAC_BITS-1:0]  sin_b,
   input  logic [15:0]           switch_period,
   output logic                  out_valid,
   input  logic                  out_ready,
   output svm_pkg::times_type    out_times
);

   localparam int AB = svm_pkg::AMP_BITS;
   localparam int PW = AB + FRAC_BITS;
   localparam int QW = AB + 16;

   // stage 4: amplitude * sine
   logic                 v4_ff;
   logic [2:0]           sector4_ff;
   logic [AB-1:0]        va_ff, va_in;
   logic [AB-1:0]        vb_ff, vb_in;
   logic [PW-1:0]        pa;
   logic [PW-1:0]        pb;
   logic                 en4;

   // stage 5: times the period
   logic                 v5_ff;
   svm_pkg::times_type   times_ff, times_in;
   logic [QW-1:0]        qa;
   logic [QW-1:0]        qb;
   logic                 en5;

   assign en5      = !v5_ff || out_ready;
   assign en4      = !v4_ff || en5;
   assign in_ready = en4;

   always_comb begin
      pa    = PW'(in_cmd.amp) * PW'(sin_a);
      pb    = PW'(in_cmd.amp) * PW'(sin_b);
      // sine < 2^FRAC_BITS, so the product fits back into the amplitude width
      va_in = AB'(pa >> FRAC_BITS);
      vb_in = AB'(pb >> FRAC_BITS);
   end

   always_comb begin
      qa = QW'(va_ff) * QW'(switch_period);
      qb = QW'(vb_ff) * QW'(switch_period);
      times_in.sector = sector4_ff;
      times_in.t1     = 16'(qa >> FRAC_BITS);
      times_in.t2     = 16'(qb >> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en4) begin
            v4_ff <= in_valid;
         end
         if (en5) begin
            v5_ff <= v4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         sector4_ff <= in_cmd.sector;
         va_ff      <= va_in;
         vb_ff      <= vb_in;
      end
      if (en5) begin
         times_ff <= times_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_times = times_ff;

endmodule

### hw/rtl/svm_timing.sv
// Zero time and per-phase compare values with phase routing (two stages).
`timescale 1ns / 1ps

module svm_timing (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  svm_pkg::times_type  in_times,
   input  logic [15:0]         switch_period,
   input  logic                discontinuous,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [2:0]          sector,
   output logic [15:0]         zero_time,
   output logic [15:0]         active_time_one,
   output logic [15:0]         active_time_two,
   output logic [15:0]         compare_u,
   output logic [15:0]         compare_v,
   output logic [15:0]         compare_w
);

   localparam logic [2:0] SECTOR_0 = 3'd0;
   localparam logic [2:0] SECTOR_1 = 3'd1;
   localparam logic [2:0] SECTOR_2 = 3'd2;
   localparam logic [2:0] SECTOR_3 = 3'd3;
   localparam logic [2:0] SECTOR_4 = 3'd4;

   // stage 6
   logic                 v6_ff;
   svm_pkg::times_type   times6_ff;
   logic [15:0]          t0_ff, t0_in;
   logic [16:0]          act_sum;
   logic [15:0]          t0_full;
   logic                 en6;

   // stage 7 (output register)
   logic                 v7_ff;
   logic [2:0]           sector_ff;
   logic [15:0]          t0_out_ff, t1_out_ff, t2_out_ff;
   logic [15:0]          cu_ff, cu_in;
   logic [15:0]          cv_ff, cv_in;
   logic [15:0]          cw_ff, cw_in;
   logic [15:0]          c0, c1, c2;
   logic                 en7;

   assign en7      = !v7_ff || out_ready;
   assign en6      = !v6_ff || en7;
   assign in_ready = en6;

   always_comb begin
      act_sum = 17'(in_times.t1) + 17'(in_times.t2);
      // zero time saturates when the active vectors overrun the period
      if (act_sum > 17'(switch_period)) begin
         t0_full = 16'd0;
      end else begin
         t0_full = switch_period - in_times.t1 - in_times.t2;
      end
      t0_in = discontinuous ? t0_full : (t0_full >> 1);
   end

   always_comb begin
      c0 = t0_ff;
      c1 = t0_ff + (times6_ff.sector[0] ? times6_ff.t2 : times6_ff.t1);
      c2 = t0_ff + times6_ff.t1 + times6_ff.t2;
      case (times6_ff.sector)
         SECTOR_0: begin
            cu_in = c0; cv_in = c1; cw_in = c2;
         end
         SECTOR_1: begin
            cv_in = c0; cu_in = c1; cw_in = c2;
         end
         SECTOR_2: begin
            cv_in = c0; cw_in = c1; cu_in = c2;
         end
         SECTOR_3: begin
            cw_in = c0; cv_in = c1; cu_in = c2;
         end
         SECTOR_4: begin
            cw_in = c0; cu_in = c1; cv_in = c2;
         end
         default: begin
            cu_in = c0; cw_in = c1; cv_in = c2;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         if (en6) begin
            v6_ff <= in_valid;
         end
         if (en7) begin
            v7_ff <= v6_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         times6_ff <= in_times;
         t0_ff     <= t0_in;
      end
      if (en7) begin
         sector_ff <= times6_ff.sector;
         t0_out_ff <= t0_ff;
         t1_out_ff <= times6_ff.t1;
         t2_out_ff <= times6_ff.t2;
         cu_ff     <= cu_in;
         cv_ff     <= cv_in;
         cw_ff     <= cw_in;
      end
   end

   assign out_valid       = v7_ff;
   assign sector          = sector_ff;
   assign zero_time       = t0_out_ff;
   assign active_time_one = t1_out_ff;
   assign active_time_two = t2_out_ff;
   assign compare_u       = cu_ff;
   assign compare_v       = cv_ff;
   assign compare_w       = cw_ff;

endmodule

### hw/rtl/space_vector_modulator.sv
// Space vector modulator: seven-stage pipeline, one request beat to one response beat.
// Each request passes the front, ROM, scale and timing stages in order, and the response
// is held in the output register until the receiver takes it.
// Throughput: one beat per cycle; each stage holds under backpressure and fills bubbles.
// Depth is set by the two ROM reads and the two chained multiplications per vector time.
// Reset (synchronous, active high) empties the pipeline and restores the CSR defaults.
`timescale 1ns / 1ps

module space_vector_modulator #(
   parameter int FRAC_BITS      = svm_pkg::FRAC_BITS_DEF,
   parameter int SINE_ADDR_BITS = svm_pkg::SINE_ADDR_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   svm_req_if.sink       req_ch,
   svm_rsp_if.source     rsp_ch,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata
);

   localparam int ROM_DEPTH     = int'(svm_pkg::A60 >> (16 - SINE_ADDR_BITS)) + 1;
   localparam int ROM_ADDR_BITS = $clog2(ROM_DEPTH);

   localparam logic [1:0] CSR_SWITCH_PERIOD   = 2'd0;
   localparam logic [1:0] CSR_AMPLITUDE_LIMIT = 2'd1;
   localparam logic [1:0] CSR_DISCONTINUOUS   = 2'd2;

   logic [15:0] period_ff;
   logic [15:0] limit_ff;
   logic        disc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= 16'd2000;
         limit_ff  <= 16'd32768;
         disc_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SWITCH_PERIOD:   period_ff <= csr_wdata;
            CSR_AMPLITUDE_LIMIT: limit_ff  <= csr_wdata;
            CSR_DISCONTINUOUS:   disc_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic                      front_valid, front_ready;
   svm_pkg::cmd_type          front_cmd;
   logic [ROM_ADDR_BITS-1:0]  addr_a, addr_b;

   logic                      rom_valid, rom_ready;
   svm_pkg::cmd_type          rom_cmd;
   logic [FRAC_BITS-1:0]      sin_a, sin_b;

   logic                      scale_valid, scale_ready;
   svm_pkg::times_type        scale_times;

   svm_front #(
      .SINE_ADDR_BITS (SINE_ADDR_BITS),
      .ROM_ADDR_BITS  (ROM_ADDR_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_ch.valid),
      .in_ready        (req_ch.ready),
      .mode            (req_ch.mode),
      .rotor_angle     (req_ch.rotor_angle),
      .command_angle   (req_ch.command_angle),
      .amplitude       (req_ch.amplitude),
      .amplitude_limit (limit_ff),
      .out_valid       (front_valid),
      .out_ready       (front_ready),
      .out_cmd         (front_cmd),
      .addr_a          (addr_a),
      .addr_b          (addr_b)
   );

   svm_sine_rom #(
      .FRAC_BITS      (FRAC_BITS),
      .SINE_ADDR_BITS (SINE_ADDR_BITS),
      .ROM_ADDR_BITS  (ROM_ADDR_BITS)
   ) u_rom (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .addr_a    (addr_a),
      .addr_b    (addr_b),
      .out_valid (rom_valid),
      .out_ready (rom_ready),
      .out_cmd   (rom_cmd),
      .sin_a     (sin_a),
      .sin_b     (sin_b)
   );

   svm_scale #(
      .FRAC_BITS (FRAC_BITS)
   ) u_scale (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (rom_valid),
      .in_ready      (rom_ready),
      .in_cmd        (rom_cmd),
      .sin_a         (sin_a),
      .sin_b         (sin_b),
      .switch_period (period_ff),
      .out_valid     (scale_valid),
      .out_ready     (scale_ready),
      .out_times     (scale_times)
   );

   svm_timing u_timing (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (scale_valid),
      .in_ready        (scale_ready),
      .in_times        (scale_times),
      .switch_period   (period_ff),
      .discontinuous   (disc_ff),
      .out_valid       (rsp_ch.valid),
      .out_ready       (rsp_ch.ready),
      .sector          (rsp_ch.sector),
      .zero_time       (rsp_ch.zero_time),
      .active_time_one (rsp_ch.active_time_one),
      .active_time_two (rsp_ch.active_time_two),
      .compare_u       (rsp_ch.compare_u),
      .compare_v       (rsp_ch.compare_v),
      .compare_w       (rsp_ch.compare_w)
   );

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("response valid right after reset");

   // sector split never produces a code above five
   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.sector <= 3'd5)
      else $error("sector out of range");

   // zero time <= period; relies on user keeping config stable while work is in flight
   a_zero_le_period: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.zero_time <= period_ff)
      else $error("zero time above period");

   // first phase of every sector pattern switches at the zero time
   a_first_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.compare_u == rsp_ch.zero_time ||
                        rsp_ch.compare_v == rsp_ch.zero_time ||
                        rsp_ch.compare_w == rsp_ch.zero_time))
      else $error("no phase carries the zero time");

endmodule

### test/tb_top.sv
// Self-checking testbench for the space vector modulator: directed, config, stall, random.
`timescale 1ns / 1ps

module tb_top;

   localparam bit [1:0] CSR_PERIOD = 2'd0;
   localparam bit [1:0] CSR_LIMIT  = 2'd1;
   localparam bit [1:0] CSR_DISC   = 2'd2;
   localparam bit [1:0] CSR_SPARE  = 2'd3;

   localparam bit MODE_DIRECT = 1'b0;
   localparam bit MODE_ROTOR  = 1'b1;

   localparam int RX_ALWAYS  = 0;
   localparam int RX_RANDOM  = 1;
   localparam int RX_PATTERN = 2;

   localparam int unsigned SEXTANT   = 10923;
   localparam int          Q_BITS    = 15;
   localparam int          ROM_BITS  = 10;
   localparam int          LUT_SHIFT = 16 - ROM_BITS;
   localparam int          LUT_LAST  = SEXTANT >> LUT_SHIFT;
   localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

   localparam int MAX_REPORTS = 40;

   typedef struct packed {
      bit [2:0]  sector;
      bit [15:0] zero_time;
      bit [15:0] t_one;
      bit [15:0] t_two;
      bit [15:0] cmp_u;
      bit [15:0] cmp_v;
      bit [15:0] cmp_w;
   } pwm_frame_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   svm_req_if cmd_bus ();
   svm_rsp_if frame_bus ();

   space_vector_modulator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (cmd_bus),
      .rsp_ch    (frame_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the registers
   int unsigned cfg_period;
   int unsigned cfg_limit;
   bit          cfg_disc;

   int unsigned   sine_lut [0:LUT_LAST];
   pwm_frame_type expected_frames [$];

   int       error_count;
   int       burst_left;
   bit       gaps_on;
   int       rx_style;
   bit [7:0] stall_pattern;
   int       hold_left;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("FAIL space_vector_modulator");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   // First-sextant sine in Q15 for ROM address k, via a Taylor series in Q30.
   function automatic int unsigned sine_entry(input int unsigned k);
      longint unsigned x, x2, term;
      longint          acc;
      x = (TWO_PI_Q30 * k) >> ROM_BITS;
      x2 = (x * x) >> 30;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      return int'((acc + (longint'(1) << (29 - Q_BITS))) >> (30 - Q_BITS));
   endfunction

   function automatic bit [15:0] scale_time(input int unsigned amp, input int unsigned s);
      longint unsigned v;
      v = (longint'(amp) * s) >> Q_BITS;
      v = (v * cfg_period) >> Q_BITS;
      return v[15:0];
   endfunction

   function automatic pwm_frame_type predict_frame(input bit mode, input bit [15:0] rotor,
         input bit [15:0] ctrl, input bit [15:0] raw_amp);
      pwm_frame_type f;
      bit [15:0]     angle;
      int unsigned   amp, sect, offset, t0, t1, t2;
      bit [15:0]     c0, c1, c2;
      angle = (mode == MODE_ROTOR) ? rotor + ctrl : ctrl;
      if (raw_amp[15]) begin
         amp = 0;
      end else if (raw_amp > cfg_limit) begin
         amp = cfg_limit;
      end else begin
         amp = 32'(raw_amp);
      end
      sect = angle / SEXTANT;
      if (sect > 5) begin
         sect = 5;
      end
      offset = angle - sect * SEXTANT;
      t1 = 32'(scale_time(amp, sine_lut[(SEXTANT - offset) >> LUT_SHIFT]));
      t2 = 32'(scale_time(amp, sine_lut[offset >> LUT_SHIFT]));
      // zero time saturates when rounding pushes the active times past the period
      t0 = (t1 + t2 > cfg_period) ? 0 : cfg_period - t1 - t2;
      if (!cfg_disc) begin
         t0 = t0 >> 1;
      end
      c0 = 16'(t0);
      c1 = 16'(t0 + (sect[0] ? t2 : t1));
      c2 = 16'(t0 + t1 + t2);
      f.sector = 3'(sect);
      f.zero_time = 16'(t0);
      f.t_one = 16'(t1);
      f.t_two = 16'(t2);
      case (sect)
         0: begin f.cmp_u = c0; f.cmp_v = c1; f.cmp_w = c2; end
         1: begin f.cmp_v = c0; f.cmp_u = c1; f.cmp_w = c2; end
         2: begin f.cmp_v = c0; f.cmp_w = c1; f.cmp_u = c2; end
         3: begin f.cmp_w = c0; f.cmp_v = c1; f.cmp_u = c2; end
         4: begin f.cmp_w = c0; f.cmp_u = c1; f.cmp_v = c2; end
         default: begin f.cmp_u = c0; f.cmp_w = c1; f.cmp_v = c2; end
      endcase
      return f;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic write_csr(input bit [1:0] idx, input bit [15:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PERIOD: cfg_period = 32'(data);
         CSR_LIMIT:  cfg_limit = 32'(data);
         CSR_DISC:   cfg_disc = data[0];
         default: ;
      endcase
   endtask

   task automatic send_command(input bit mode, input bit [15:0] rotor,
         input bit [15:0] ctrl, input bit [15:0] amp);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gaps_on && gap > 0) begin
            @(negedge clock);
            cmd_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      cmd_bus.valid <= 1'b1;
      cmd_bus.mode <= mode;
      cmd_bus.rotor_angle <= rotor;
      cmd_bus.command_angle <= ctrl;
      cmd_bus.amplitude <= amp;
      do @(posedge clock); while (cmd_bus.ready !== 1'b1);
      expected_frames.push_back(predict_frame(mode, rotor, ctrl, amp));
   endtask

   task automatic send_random();
      bit [15:0] ctrl, amp;
      int        s;
      if ($urandom_range(0, 3) == 0) begin
         // land near a sector boundary
         s = $urandom_range(0, 6);
         ctrl = 16'(s * SEXTANT + $urandom_range(0, 6) - 3);
      end else begin
         ctrl = 16'($urandom);
      end
      case ($urandom_range(0, 5))
         0: amp = 16'(cfg_limit + $urandom_range(0, 8) - 4);
         1: amp = 16'($urandom_range(0, 64));
         default: amp = 16'($urandom);
      endcase
      send_command(1'($urandom_range(0, 1)), 16'($urandom), ctrl, amp);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      cmd_bus.valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
   endtask

   // Receiver: long hold-off first, else the current stall style
   always @(negedge clock) begin
      if (hold_left > 0) begin
         frame_bus.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         case (rx_style)
            RX_RANDOM: frame_bus.ready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: begin
               frame_bus.ready <= stall_pattern[0];
               stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
            end
            default: frame_bus.ready <= 1'b1;
         endcase
      end
   end

   // ---------------------------------------------------------------- checker

   task automatic check_field(input string label, input logic [15:0] want,
         input logic [15:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      pwm_frame_type want;
      if (!reset && frame_bus.valid === 1'b1 && frame_bus.ready === 1'b1) begin
         if (expected_frames.size() == 0) begin
            error_count++;
            $display("%0t: unexpected beat, expected none actual sector %0d", $time,
                     frame_bus.sector);
         end else begin
            want = expected_frames.pop_front();
            check_field("sector", {13'd0, want.sector}, {13'd0, frame_bus.sector});
            check_field("zero_time", want.zero_time, frame_bus.zero_time);
            check_field("active_time_one", want.t_one, frame_bus.active_time_one);
            check_field("active_time_two", want.t_two, frame_bus.active_time_two);
            check_field("compare_u", want.cmp_u, frame_bus.compare_u);
            check_field("compare_v", want.cmp_v, frame_bus.compare_v);
            check_field("compare_w", want.cmp_w, frame_bus.compare_w);
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      rx_style = RX_ALWAYS;
      gaps_on = 1'b0;
      // sector edges and extremes of the angle
      send_command(MODE_DIRECT, 16'd0, 16'd0, 16'd16384);
      send_command(MODE_DIRECT, 16'd0, 16'd10922, 16'd32767);
      send_command(MODE_DIRECT, 16'd0, 16'd10923, 16'd32767);
      send_command(MODE_DIRECT, 16'd0, 16'd21845, 16'd20000);
      send_command(MODE_DIRECT, 16'd0, 16'd21846, 16'd20000);
      send_command(MODE_DIRECT, 16'd0, 16'd32768, 16'd32767);
      send_command(MODE_DIRECT, 16'd0, 16'd43692, 16'd12345);
      send_command(MODE_DIRECT, 16'd0, 16'd54614, 16'd30000);
      send_command(MODE_DIRECT, 16'd0, 16'd54615, 16'd30000);
      send_command(MODE_DIRECT, 16'hFFFF, 16'd65535, 16'd32767);
      // mid-sector at full scale, where rounding can exceed the period
      send_command(MODE_DIRECT, 16'd0, 16'd5461, 16'd32767);
      send_command(MODE_DIRECT, 16'd0, 16'd27306, 16'd32767);
      // negative and zero amplitudes
      send_command(MODE_DIRECT, 16'd0, 16'd7000, 16'h8000);
      send_command(MODE_DIRECT, 16'd0, 16'd7000, 16'hFFFF);
      send_command(MODE_DIRECT, 16'd0, 16'd7000, 16'd0);
      send_command(MODE_DIRECT, 16'd0, 16'd7000, 16'd1);
      // rotor plus advance, with wrap
      send_command(MODE_ROTOR, 16'd65535, 16'd1, 16'd25000);
      send_command(MODE_ROTOR, 16'd40000, 16'd40000, 16'd25000);
      send_command(MODE_ROTOR, 16'd0, 16'd65535, 16'd25000);
      send_command(MODE_ROTOR, 16'd12345, 16'd0, 16'd25000);
      send_command(MODE_ROTOR, 16'hFFFF, 16'hFFFF, 16'h7FFF);
      send_command(MODE_ROTOR, 16'hAAAA, 16'h5555, 16'h5555);
      wait_idle();
   endtask

   task automatic run_phase(input bit [15:0] period, input bit [15:0] limit,
         input bit disc, input int count);
      wait_idle();
      write_csr(CSR_PERIOD, period);
      write_csr(CSR_LIMIT, limit);
      write_csr(CSR_DISC, {15'd0, disc});
      repeat (count) send_random();
   endtask

   task automatic test_config_sweep();
      rx_style = RX_RANDOM;
      gaps_on = 1'b1;
      run_phase(16'd65535, 16'd32768, 1'b1, 55);
      run_phase(16'd1, 16'd0, 1'b0, 55);
      run_phase(16'd0, 16'd32768, 1'b0, 55);
      run_phase(16'd2000, 16'd16384, 1'b1, 0);
      // unused index must not disturb any register
      write_csr(CSR_SPARE, 16'($urandom));
      repeat (55) send_random();
      run_phase(16'd65535, 16'd1, 1'b0, 55);
      rx_style = RX_PATTERN;
      stall_pattern = 8'($urandom) | 8'h01;
      run_phase(16'd40000, 16'd32767, 1'b1, 55);
      wait_idle();
   endtask

   task automatic test_backpressure();
      rx_style = RX_ALWAYS;
      gaps_on = 1'b0;
      hold_left = 150;
      repeat (40) send_random();
      wait_idle();
   endtask

   task automatic test_random_traffic();
      for (int chunk = 0; chunk < 6; chunk++) begin
         rx_style = chunk % 3;
         stall_pattern = 8'($urandom) | 8'h01;
         gaps_on = (chunk != 0);
         case ($urandom_range(0, 2))
            0: run_phase(16'($urandom_range(1, 60)), 16'($urandom_range(0, 32768)),
                         1'($urandom_range(0, 1)), 95);
            1: run_phase(16'($urandom_range(60000, 65535)), 16'($urandom_range(0, 32768)),
                         1'($urandom_range(0, 1)), 95);
            default: run_phase(16'($urandom_range(1, 65535)),
                               16'($urandom_range(0, 32768)),
                               1'($urandom_range(0, 1)), 95);
         endcase
      end
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = 2'd0;
      csr_wdata = 16'd0;
      cmd_bus.valid = 1'b0;
      cmd_bus.mode = 1'b0;
      cmd_bus.rotor_angle = 16'd0;
      cmd_bus.command_angle = 16'd0;
      cmd_bus.amplitude = 16'sd0;
      frame_bus.ready = 1'b0;
      cfg_period = 2000;
      cfg_limit = 32768;
      cfg_disc = 1'b0;
      error_count = 0;
      burst_left = 0;
      gaps_on = 1'b0;
      rx_style = RX_ALWAYS;
      stall_pattern = 8'hFF;
      hold_left = 0;
      for (int k = 0; k <= LUT_LAST; k++) begin
         sine_lut[k] = sine_entry(k);
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_config_sweep();
      test_backpressure();
      test_random_traffic();

      wait_idle();
      // stragglers past the pipeline depth would show up as unexpected beats
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS space_vector_modulator");
      end else begin
         $display("FAIL space_vector_modulator");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/svm_pkg.sv
hw/rtl/svm_req_if.sv
hw/rtl/svm_rsp_if.sv
hw/rtl/svm_front.sv
hw/rtl/svm_sine_rom.sv
hw/rtl/svm_scale.sv
hw/rtl/svm_timing.sv
hw/rtl/space_vector_modulator.sv
test/tb_top.sv
